// ===== sv/all_pairs_shortest_path_unit_defines.svh =====
// Assertion macros for the all-pairs shortest path unit.
// Used by the sequencer and the top level; expects clk and rst in scope.
`ifndef ALL_PAIRS_SHORTEST_PATH_UNIT_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define APSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/apsp_pkg.sv =====
// Shared types and command codes for the all-pairs shortest path unit.
// No dependencies.
`timescale 1ns / 1ps

package apsp_pkg;

  localparam int CMD_W   = 2;
  localparam int NODE_W  = 6;
  localparam int WEIGHT_W = 32;
  localparam int COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [NODE_W-1:0]   row;
    logic [NODE_W-1:0]   col;
    logic [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] distance;
    logic                run_done;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } relax_stat_t;

endpackage

// ===== sv/all_pairs_shortest_path_unit.sv =====
// All-pairs shortest path unit: command decode, result register, table and sequencer.
// Depends on apsp_pkg, apsp_dist_mem, apsp_relax_seq and the assertion macro header.
//
// Input channel in_valid/in_ready/in_data carries one command per transaction:
// write stores one table entry, run relaxes the table in place, read fetches one entry.
// Output channel out_valid/out_ready/out_data returns one result per run or read.
// cfg_we/cfg_wdata sets the active node count n (reset 64, clipped to MAX_NODES).
// A write gives no result; the next command is taken the next cycle.
// In a read the table read is registered, then the result register loads.
// A run walks n pivots by n sources; each source row is read through S_IK_RD, S_IK_LD
// and S_STREAM on the two-read, one-write table; a run holds the input until it ends.
// Reads and writes outside the table are handled in decode: a read returns all ones.
// The result register holds until out_ready; while it is full a finished read or run
// waits in its own state and the input is held, so writes flow only in the idle state.
// Synchronous reset clears the state machines and out_valid; node count resets to 64;
// the table itself is not cleared and is undefined until written.
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_unit_defines.svh"

module all_pairs_shortest_path_unit #(
  parameter int MAX_NODES  = 64,
  parameter int DIST_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  apsp_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output apsp_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [apsp_pkg::COUNT_W-1:0] cfg_wdata
);

  import apsp_pkg::*;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int ADDR_W = 2 * IDX_W;

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_RUN,
    T_DONE
  } top_state_t;

  top_state_t           state;
  logic [COUNT_W-1:0]   node_count;
  logic                 oor;
  logic                 accept;
  logic                 in_range;
  logic                 host_wr;
  logic                 host_rd;
  logic                 run_start;
  logic                 out_free;
  logic                 out_load;
  logic [CNT_W-1:0]     n_eff;
  logic [ADDR_W-1:0]    host_addr;

  logic                 mem_wr_en;
  logic [ADDR_W-1:0]    mem_wr_addr;
  logic [DIST_WIDTH-1:0] mem_wr_data;
  logic                 mem_rd_en_a;
  logic [ADDR_W-1:0]    mem_rd_addr_a;
  logic [DIST_WIDTH-1:0] mem_rd_data_a;
  logic [DIST_WIDTH-1:0] mem_rd_data_b;

  logic                 seq_rd_en_a;
  logic [ADDR_W-1:0]    seq_rd_addr_a;
  logic                 seq_rd_en_b;
  logic [ADDR_W-1:0]    seq_rd_addr_b;
  logic                 seq_wr_en;
  logic [ADDR_W-1:0]    seq_wr_addr;
  logic [DIST_WIDTH-1:0] seq_wr_data;
  relax_stat_t          stat;

  assign in_ready  = (state == T_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_range  = (int'(in_data.row) < MAX_NODES) && (int'(in_data.col) < MAX_NODES);
  assign host_addr = {IDX_W'(in_data.row), IDX_W'(in_data.col)};
  assign host_wr   = accept && (in_data.command == CMD_WRITE) && in_range;
  assign host_rd   = accept && (in_data.command == CMD_READ) && in_range;
  assign run_start = accept && (in_data.command == CMD_RUN);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = out_free && ((state == T_READ) || (state == T_DONE));

  assign n_eff = (int'(node_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);

  assign mem_wr_en     = host_wr || seq_wr_en;
  assign mem_wr_addr   = host_wr ? host_addr : seq_wr_addr;
  assign mem_wr_data   = host_wr ? DIST_WIDTH'(in_data.weight) : seq_wr_data;
  assign mem_rd_en_a   = host_rd || seq_rd_en_a;
  assign mem_rd_addr_a = host_rd ? host_addr : seq_rd_addr_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            case (in_data.command)
              CMD_RUN: begin
                state <= T_RUN;
              end
              CMD_READ: begin
                oor   <= !in_range;
                state <= T_READ;
              end
              default: begin
                state <= T_IDLE;
              end
            endcase
          end
        end
        T_READ: begin
          if (out_free) begin
            out_data.distance <= oor ? WEIGHT_W'({DIST_WIDTH{1'b1}})
                                     : WEIGHT_W'(mem_rd_data_a);
            out_data.run_done <= 1'b0;
            state             <= T_IDLE;
          end
        end
        T_RUN: begin
          if (stat.done) begin
            state <= T_DONE;
          end
        end
        T_DONE: begin
          if (out_free) begin
            out_data.distance <= '0;
            out_data.run_done <= 1'b1;
            state             <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  apsp_dist_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (DIST_WIDTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en_a   (mem_rd_en_a),
    .rd_addr_a (mem_rd_addr_a),
    .rd_data_a (mem_rd_data_a),
    .rd_en_b   (seq_rd_en_b),
    .rd_addr_b (seq_rd_addr_b),
    .rd_data_b (mem_rd_data_b)
  );

  apsp_relax_seq #(
    .IDX_W  (IDX_W),
    .CNT_W  (CNT_W),
    .DATA_W (DIST_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (run_start),
    .n_eff     (n_eff),
    .rd_data_a (mem_rd_data_a),
    .rd_data_b (mem_rd_data_b),
    .rd_en_a   (seq_rd_en_a),
    .rd_addr_a (seq_rd_addr_a),
    .rd_en_b   (seq_rd_en_b),
    .rd_addr_b (seq_rd_addr_b),
    .wr_en     (seq_wr_en),
    .wr_addr   (seq_wr_addr),
    .wr_data   (seq_wr_data),
    .stat      (stat)
  );

  `APSP_ASSERT_NOW(a_no_accept_in_run, stat.busy, !in_ready, "command taken during a run")
  `APSP_ASSERT_NOW(a_host_seq_wr, host_wr || host_rd, !seq_wr_en && !seq_rd_en_a, "host and sequencer share a port")
  `APSP_ASSERT_NOW(a_done_in_run, stat.done, state == T_RUN, "run finished outside run state")

endmodule

// ===== sv/apsp_dist_mem.sv =====
// Distance table: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module apsp_dist_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en_a,
  input  logic [ADDR_W-1:0] rd_addr_a,
  output logic [DATA_W-1:0] rd_data_a,
  input  logic              rd_en_b,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_b
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_a) begin
      rd_data_a <= mem[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_b) begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== sv/apsp_relax_seq.sv =====
// Relaxation sequencer: walks pivot, source, target over the distance table.
// Depends on apsp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_unit_defines.svh"

module apsp_relax_seq #(
  parameter int IDX_W  = 6,
  parameter int CNT_W  = 7,
  parameter int DATA_W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CNT_W-1:0]      n_eff,
  input  logic [DATA_W-1:0]     rd_data_a,
  input  logic [DATA_W-1:0]     rd_data_b,
  output logic                  rd_en_a,
  output logic [2*IDX_W-1:0]    rd_addr_a,
  output logic                  rd_en_b,
  output logic [2*IDX_W-1:0]    rd_addr_b,
  output logic                  wr_en,
  output logic [2*IDX_W-1:0]    wr_addr,
  output logic [DATA_W-1:0]     wr_data,
  output apsp_pkg::relax_stat_t stat
);

  import apsp_pkg::*;

  localparam int ADDR_W = 2 * IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IK_RD,
    S_IK_LD,
    S_STREAM,
    S_FIN
  } seq_state_t;

  seq_state_t        state;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  n_last;
  logic [DATA_W-1:0] dik;
  logic              p_vld;
  logic [ADDR_W-1:0] p_addr;
  logic [DATA_W-1:0] via;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
  endfunction

  assign rd_en_a   = (state == S_IK_RD) || (state == S_STREAM);
  assign rd_addr_a = (state == S_IK_RD) ? {i, k} : {k, j};
  assign rd_en_b   = (state == S_STREAM);
  assign rd_addr_b = {i, j};

  assign via     = sat_add(dik, rd_data_a);
  assign wr_en   = p_vld;
  assign wr_addr = p_addr;
  assign wr_data = (via < rd_data_b) ? via : rd_data_b;

  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      i     <= '0;
      j     <= '0;
      p_vld <= 1'b0;
    end else begin
      p_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            k <= '0;
            i <= '0;
            j <= '0;
            n_last <= IDX_W'(n_eff - CNT_W'(1));
            state <= (n_eff == '0) ? S_FIN : S_IK_RD;
          end
        end
        S_IK_RD: begin
          state <= S_IK_LD;
        end
        S_IK_LD: begin
          dik   <= rd_data_a;
          j     <= '0;
          state <= S_STREAM;
        end
        S_STREAM: begin
          p_vld  <= 1'b1;
          p_addr <= {i, j};
          if (j == n_last) begin
            j <= '0;
            if (i == n_last) begin
              i <= '0;
              if (k == n_last) begin
                k     <= '0;
                state <= S_FIN;
              end else begin
                k     <= k + IDX_W'(1);
                state <= S_IK_RD;
              end
            end else begin
              i     <= i + IDX_W'(1);
              state <= S_IK_RD;
            end
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `APSP_ASSERT_NOW(a_wr_vs_rd_a, wr_en && rd_en_a, wr_addr != rd_addr_a, "write collides with read A")
  `APSP_ASSERT_NOW(a_wr_vs_rd_b, wr_en && rd_en_b, wr_addr != rd_addr_b, "write collides with read B")
  `APSP_ASSERT_NEXT(a_wr_after_stream, state == S_STREAM, wr_en, "relaxed entry not written back")

endmodule
